@@ rtl/core/priority_beep_pattern_sequencer_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the priority beep pattern sequencer
// Shared immediate-style wrappers around concurrent properties.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_BEEP_PATTERN_SEQUENCER_TOP_ASSERT_SVH
`define PRIORITY_BEEP_PATTERN_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define PBPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define PBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/pbps_pkg.sv @@
// ---------------------------------------------------------------------------
// pbps_pkg
// Types, codes and pattern tables of the priority beep pattern sequencer.
// ---------------------------------------------------------------------------
package pbps_pkg;

    localparam int NUM_PATTERNS = 5;
    localparam int MS_W         = 10;
    localparam int STEP_W       = 4;
    localparam int PAT_W        = 3;
    localparam int RANK_W       = 2;
    localparam int LEN_W        = 4;
    localparam int CFG_IDX_W    = 1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PLAY  = 2'd1,
        OP_CLICK = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_ENA = 1'b1;

    localparam logic [PAT_W-1:0] PAT_CHIRP    = 3'd0;
    localparam logic [PAT_W-1:0] PAT_OK       = 3'd1;
    localparam logic [PAT_W-1:0] PAT_FAIL     = 3'd2;
    localparam logic [PAT_W-1:0] PAT_REMINDER = 3'd3;
    localparam logic [PAT_W-1:0] PAT_MISSED   = 3'd4;

    typedef struct packed {
        op_t              op;
        logic [PAT_W-1:0] pattern;
        logic             from_keyboard;
    } item_t;

    typedef struct packed {
        logic             accepted;
        logic [PAT_W-1:0] playing_pattern;
        logic             busy_res;
        logic             buzzer_on;
    } result_t;

    // step duration in ms; zero past the end of a pattern
    function automatic logic [MS_W-1:0] step_ms(input logic [PAT_W-1:0] p,
                                                input logic [STEP_W-1:0] idx);
        logic [MS_W-1:0] ms;
        ms = '0;
        case (p)
            PAT_CHIRP: begin
                if (idx == 4'd0) ms = 10'd10;
            end
            PAT_OK: begin
                if (idx < 4'd3) ms = idx[0] ? 10'd70 : 10'd80;
            end
            PAT_FAIL: begin
                if (idx < 4'd7) ms = 10'd60;
            end
            PAT_REMINDER: begin
                if (idx < 4'd11) begin
                    case (idx[1:0])
                        2'd1:    ms = 10'd120;
                        2'd3:    ms = 10'd400;
                        default: ms = 10'd150;
                    endcase
                end
            end
            PAT_MISSED: begin
                if (idx < 4'd15) begin
                    if (idx == 4'd7)  ms = 10'd700;
                    else if (idx[0])  ms = 10'd200;
                    else              ms = 10'd500;
                end
            end
            default: ms = '0;
        endcase
        return ms;
    endfunction

    function automatic logic [LEN_W-1:0] seq_len(input logic [PAT_W-1:0] p);
        logic [LEN_W-1:0] n;
        case (p)
            PAT_CHIRP:    n = 4'd1;
            PAT_OK:       n = 4'd3;
            PAT_FAIL:     n = 4'd7;
            PAT_REMINDER: n = 4'd11;
            PAT_MISSED:   n = 4'd15;
            default:      n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [RANK_W-1:0] pat_rank(input logic [PAT_W-1:0] p);
        logic [RANK_W-1:0] r;
        case (p)
            PAT_CHIRP:    r = 2'd0;
            PAT_OK:       r = 2'd1;
            PAT_FAIL:     r = 2'd2;
            PAT_REMINDER: r = 2'd2;
            PAT_MISSED:   r = 2'd3;
            default:      r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/pbps_ctrl.sv @@
// ---------------------------------------------------------------------------
// pbps_ctrl
// Playback state, configuration registers and next-state logic per word.
// ---------------------------------------------------------------------------
module pbps_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [pbps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                             cfg_data,
    input  logic                             item_valid,
    input  pbps_pkg::item_t                  item,
    output pbps_pkg::result_t                result
);
    import pbps_pkg::*;

    logic              enable_reg, click_en_reg;
    logic              playing_reg, playing_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [PAT_W-1:0]  pat_reg, pat_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [MS_W-1:0]   ms_reg, ms_next;
    logic              acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            click_en_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ENABLE:    enable_reg   <= cfg_data;
                CFG_CLICK_ENA: click_en_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb begin
        logic              req_en;
        logic [PAT_W-1:0]  req_pat;
        logic [MS_W-1:0]   ms_dec;
        logic [STEP_W:0]   step_inc;

        playing_next = playing_reg;
        rank_next    = rank_reg;
        pat_next     = pat_reg;
        step_next    = step_reg;
        ms_next      = ms_reg;
        acc          = 1'b0;
        req_en       = 1'b0;
        req_pat      = PAT_CHIRP;
        ms_dec       = (ms_reg != '0) ? ms_reg - 1'b1 : '0;
        step_inc     = {1'b0, step_reg} + 1'b1;

        unique case (item.op)
            OP_TICK: begin
                if (playing_reg) begin
                    ms_next = ms_dec;
                    if (ms_dec == '0) begin
                        if (pat_reg >= PAT_W'(NUM_PATTERNS) ||
                            step_inc >= {1'b0, seq_len(pat_reg)}) begin
                            playing_next = 1'b0;
                            rank_next    = '0;
                            pat_next     = '0;
                            step_next    = '0;
                            ms_next      = '0;
                        end else begin
                            step_next = step_inc[STEP_W-1:0];
                            ms_next   = step_ms(pat_reg, step_inc[STEP_W-1:0]);
                        end
                    end
                end
            end
            OP_PLAY: begin
                req_en  = 1'b1;
                req_pat = item.pattern;
            end
            OP_CLICK: begin
                // keyboard clicks need click_enable
                req_en  = !(item.from_keyboard && !click_en_reg);
                req_pat = PAT_CHIRP;
            end
            OP_STOP: begin
                playing_next = 1'b0;
                rank_next    = '0;
                pat_next     = '0;
                step_next    = '0;
                ms_next      = '0;
            end
            default: ;
        endcase

        // equal rank never preempts
        if (req_en && enable_reg && req_pat < PAT_W'(NUM_PATTERNS) &&
            !(playing_reg && pat_rank(req_pat) <= rank_reg)) begin
            acc          = 1'b1;
            playing_next = 1'b1;
            rank_next    = pat_rank(req_pat);
            pat_next     = req_pat;
            step_next    = '0;
            ms_next      = step_ms(req_pat, '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            playing_reg <= 1'b0;
            rank_reg    <= '0;
            pat_reg     <= '0;
            step_reg    <= '0;
            ms_reg      <= '0;
        end else if (item_valid) begin
            playing_reg <= playing_next;
            rank_reg    <= rank_next;
            pat_reg     <= pat_next;
            step_reg    <= step_next;
            ms_reg      <= ms_next;
        end
    end

    always_comb begin
        result.buzzer_on       = playing_next && !step_next[0];
        result.busy_res        = playing_next;
        result.playing_pattern = playing_next ? pat_next : '0;
        result.accepted        = acc;
    end

endmodule

@@ rtl/core/priority_beep_pattern_sequencer_top.sv @@
// ---------------------------------------------------------------------------
// priority_beep_pattern_sequencer_top
// Ranked beep pattern player: one result word per input word.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel carries one word per event: s_tuser is the kind (tick,
//   play, tap click, stop), s_tdata the pattern number and keyboard flag.
//   m_ channel returns exactly one word per input word, in order: buzzer
//   level, busy, playing pattern and whether the word started a pattern.
//   cfg_ channel writes enable (index 0) and click_enable (index 1); it is always
//   ready. The user must write it only while no word is in flight; not enforced.
// Timing:
//   A word accepted on s_ lands in the input register and moves to the
//   result register, raising m_tvalid, once that register is empty or read.
//   Throughput is one word per cycle while m_tready stays high; the playback state
//   updates in a single pass as the word leaves the input register.
// Reset:
//   aresetn low clears both config bits, the playback state and both
//   valid flags; the line reads off and no pattern plays.
// Backpressure:
//   With m_tready low the result word holds and the input register fills,
//   then s_tready drops; no word is lost or repeated.
// ---------------------------------------------------------------------------
module priority_beep_pattern_sequencer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [2:0] pattern, [3] from_keyboard
    input  logic [1:0]                     s_tuser,  // [1:0] op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] buzzer_on, [1] busy_res, [4:2] playing_pattern, [5] accepted
    output logic [7:0]                     m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data
);
    import pbps_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    result_t res;
    logic    advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_comb begin
        if (s_tvalid && s_tready) in_valid_next = 1'b1;
        else if (advance)         in_valid_next = 1'b0;
        else                      in_valid_next = in_valid_reg;

        if (advance)       out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
        else               out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.op            <= op_t'(s_tuser);
            in_item_reg.pattern       <= s_tdata[2:0];
            in_item_reg.from_keyboard <= s_tdata[3];
        end
        if (advance) out_res_reg <= res;
    end

    pbps_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (advance),
        .item       (in_item_reg),
        .result     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.accepted, out_res_reg.playing_pattern,
                       out_res_reg.busy_res, out_res_reg.buzzer_on};

endmodule

@@ rtl/core/pbps_checker.sv @@
// ---------------------------------------------------------------------------
// pbps_checker
// Port-level checks on the result channel of the sequencer top.
// ---------------------------------------------------------------------------
module pbps_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    `include "priority_beep_pattern_sequencer_top_assert.svh"

    // stalled result word holds
    `PBPS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // idle words show line off and pattern 0
    `PBPS_ASSERT_NOW(a_idle_quiet, aclk, aresetn, m_tvalid && !m_tdata[1],
        !m_tdata[0] && m_tdata[4:2] == 3'd0 && !m_tdata[5],
        "idle result with line on, pattern set or accepted")

    // a busy word names one of the five patterns
    `PBPS_ASSERT_NOW(a_pat_range, aclk, aresetn, m_tvalid && m_tdata[1],
        m_tdata[4:2] <= 3'd4 && m_tdata[7:6] == 2'b00,
        "playing pattern out of range")

    // a word that started a pattern is on its first step, line on
    `PBPS_ASSERT_NOW(a_accept_on, aclk, aresetn, m_tvalid && m_tdata[5],
        m_tdata[1] && m_tdata[0], "started pattern not sounding")

    // an empty result register never holds off the input
    `PBPS_ASSERT_NOW(a_ready_empty, aclk, aresetn, !m_tvalid, s_tready,
        "input stalled with no result waiting")

endmodule

bind priority_beep_pattern_sequencer_top pbps_checker u_pbps_checker (.*);
